// ----- sv/bcte_pkg.sv -----
// shared types, constants and the month offset table for the bcd calendar
// to epoch time unit; no dependencies
package bcte_pkg;

   localparam int unsigned PRESCALER_WIDTH = 15;
   localparam int unsigned SUBSECOND_WIDTH = 16;
   localparam int unsigned TIME_WIDTH      = 23;
   localparam int unsigned DATE_WIDTH      = 24;
   localparam int unsigned EPOCH_WIDTH     = 32;
   localparam int unsigned FRAC_WIDTH      = 30;
   localparam int unsigned DAYS_WIDTH      = 17;
   localparam int unsigned SOD_WIDTH       = 18;
   localparam int unsigned NUM_WIDTH       = PRESCALER_WIDTH + FRAC_WIDTH;

   localparam logic [PRESCALER_WIDTH-1:0] PRESCALER_RESET = 15'd255;
   localparam logic [DAYS_WIDTH-1:0]      DAYS_1970_TO_2000 = 17'h02acd;
   localparam logic [DAYS_WIDTH-1:0]      DAYS_PER_YEAR = 17'd365;
   localparam logic [33:0]                SECONDS_PER_DAY = 34'd86400;
   localparam logic [SOD_WIDTH-1:0]       SECONDS_PER_HOUR = 18'd3600;
   localparam logic [SOD_WIDTH-1:0]       SECONDS_PER_MINUTE = 18'd60;
   localparam logic [FRAC_WIDTH-1:0]      NS_PER_SECOND = 30'd1000000000;

   typedef struct packed {
      logic                       valid;
      logic                       bad;
      logic [PRESCALER_WIDTH-1:0] diff;
      logic [DAYS_WIDTH-1:0]      days;
      logic [SOD_WIDTH-1:0]       sod;
   } decode_type;

   typedef struct packed {
      logic                       valid;
      logic                       bad;
      logic [EPOCH_WIDTH-1:0]     epoch;
      logic [PRESCALER_WIDTH-1:0] rem;
      logic [FRAC_WIDTH-1:0]      word;
   } cell_type;

   // days before the month, common year; leap years add one from march on
   function automatic logic [8:0] month_offset(input logic leap, input logic [3:0] idx);
      logic [8:0] base;
      unique case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + 9'((leap && (idx >= 4'd2)) ? 1 : 0);
   endfunction

endpackage

// ----- sv/bcte_req_if.sv -----
// item channel carrying one bcd calendar snapshot
// depends on bcte_pkg
interface bcte_req_if;
   logic                                valid;
   logic                                ready;
   logic [bcte_pkg::TIME_WIDTH-1:0]     time_word;
   logic [bcte_pkg::DATE_WIDTH-1:0]     date_word;
   logic [bcte_pkg::SUBSECOND_WIDTH-1:0] subsecond;

   modport source (output valid, time_word, date_word, subsecond, input ready);
   modport sink (input valid, time_word, date_word, subsecond, output ready);
endinterface

// ----- sv/bcte_rsp_if.sv -----
// item channel carrying one epoch time result
// depends on bcte_pkg
interface bcte_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bcte_pkg::EPOCH_WIDTH-1:0] epoch_seconds;
   logic [bcte_pkg::FRAC_WIDTH-1:0]  fraction_ns;
   logic                             bad_fields;

   modport source (output valid, epoch_seconds, fraction_ns, bad_fields, input ready);
   modport sink (input valid, epoch_seconds, fraction_ns, bad_fields, output ready);
endinterface

// ----- sv/bcte_decode.sv -----
// two front stages: bcd decode and field checks, then the epoch and
// fraction numerator products feeding the divide chain; depends on bcte_pkg
module bcte_decode (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 req_valid,
   input  logic [bcte_pkg::TIME_WIDTH-1:0]      req_time_word,
   input  logic [bcte_pkg::DATE_WIDTH-1:0]      req_date_word,
   input  logic [bcte_pkg::SUBSECOND_WIDTH-1:0] req_subsecond,
   input  logic [bcte_pkg::PRESCALER_WIDTH-1:0] prescaler,
   output bcte_pkg::cell_type                   cell_out
);

   bcte_pkg::decode_type dec_in, dec_ff;
   bcte_pkg::cell_type   prod_in, prod_ff;

   logic [6:0] sec, min;
   logic [5:0] hour, day;
   logic [4:0] mon;
   logic [7:0] year;
   logic       digit_bad, mon_bad, leap;
   logic [3:0] mon_idx;
   logic [8:0] year_quarter;
   logic [bcte_pkg::SUBSECOND_WIDTH-1:0] p_wide;
   logic [bcte_pkg::NUM_WIDTH-1:0]       num;

   always_comb begin
      sec  = 7'(req_time_word[6:4]) * 7'd10 + 7'(req_time_word[3:0]);
      min  = 7'(req_time_word[14:12]) * 7'd10 + 7'(req_time_word[11:8]);
      hour = 6'(req_time_word[21:20]) * 6'd10 + 6'(req_time_word[19:16]);
      day  = 6'(req_date_word[5:4]) * 6'd10 + 6'(req_date_word[3:0]);
      mon  = 5'(req_date_word[12]) * 5'd10 + 5'(req_date_word[11:8]);
      year = 8'(req_date_word[23:20]) * 8'd10 + 8'(req_date_word[19:16]);

      digit_bad = (req_time_word[3:0] > 4'd9) || (req_time_word[11:8] > 4'd9)
               || (req_time_word[19:16] > 4'd9) || (req_date_word[3:0] > 4'd9)
               || (req_date_word[11:8] > 4'd9) || (req_date_word[19:16] > 4'd9)
               || (req_date_word[23:20] > 4'd9);
      mon_bad  = (mon == 5'd0) || (mon > 5'd12);
      mon_idx  = mon_bad ? 4'd0 : 4'(mon - 5'd1);
      leap     = (year[1:0] == 2'd0);
      year_quarter = (9'(year) + 9'd3) >> 2;
      p_wide   = {1'b0, prescaler};

      dec_in.valid = req_valid;
      dec_in.bad   = digit_bad || mon_bad || (day == 6'd0) || (prescaler == '0)
                  || (req_subsecond > p_wide);
      dec_in.diff  = (req_subsecond < p_wide)
                   ? bcte_pkg::PRESCALER_WIDTH'(p_wide - req_subsecond - 16'd1) : '0;
      dec_in.days  = bcte_pkg::DAYS_1970_TO_2000
                   + 17'(year) * bcte_pkg::DAYS_PER_YEAR
                   + 17'(year_quarter)
                   + 17'(bcte_pkg::month_offset(leap, mon_idx))
                   + 17'(day) - 17'd1;
      dec_in.sod   = 18'(hour) * bcte_pkg::SECONDS_PER_HOUR
                   + 18'(min) * bcte_pkg::SECONDS_PER_MINUTE + 18'(sec);
   end

   always_comb begin
      num = bcte_pkg::NUM_WIDTH'(dec_ff.diff) * bcte_pkg::NUM_WIDTH'(bcte_pkg::NS_PER_SECOND);
      prod_in.valid = dec_ff.valid;
      prod_in.bad   = dec_ff.bad;
      prod_in.epoch = bcte_pkg::EPOCH_WIDTH'(34'(dec_ff.days) * bcte_pkg::SECONDS_PER_DAY)
                    + bcte_pkg::EPOCH_WIDTH'(dec_ff.sod);
      prod_in.rem   = num[bcte_pkg::NUM_WIDTH-1:bcte_pkg::FRAC_WIDTH];
      prod_in.word  = num[bcte_pkg::FRAC_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff.valid  <= 1'b0;
         prod_ff.valid <= 1'b0;
      end else if (advance) begin
         dec_ff  <= dec_in;
         prod_ff <= prod_in;
      end
   end

   assign cell_out = prod_ff;

endmodule

// ----- sv/bcte_div_cell.sv -----
// one restoring divide cell: settles one quotient bit of the fraction and
// passes the item on to its neighbor; depends on bcte_pkg
module bcte_div_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic [bcte_pkg::PRESCALER_WIDTH-1:0] prescaler,
   input  bcte_pkg::cell_type                   cell_in_prev,
   output bcte_pkg::cell_type                   cell_out
);

   bcte_pkg::cell_type cell_in, cell_ff;
   logic [bcte_pkg::PRESCALER_WIDTH:0] trial, divisor;
   logic                               ge;

   always_comb begin
      trial   = {cell_in_prev.rem, cell_in_prev.word[bcte_pkg::FRAC_WIDTH-1]};
      divisor = {1'b0, prescaler};
      ge      = (trial >= divisor);
      cell_in = cell_in_prev;
      cell_in.rem  = ge ? bcte_pkg::PRESCALER_WIDTH'(trial - divisor)
                        : trial[bcte_pkg::PRESCALER_WIDTH-1:0];
      cell_in.word = {cell_in_prev.word[bcte_pkg::FRAC_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ----- sv/bcd_calendar_to_epoch_time_unit.sv -----
// from item accept to result valid an item passes two front stages,
// then one divide cell per fraction bit, 30 cells, the last one registered out
// throughput: one item per cycle; the whole chain advances unless the result
// stalls, and a stalled result holds the chain
// reset: synchronous, clears all stage valids and loads prescaler 255
// depends on bcte_pkg, bcte_req_if, bcte_rsp_if, bcte_decode, bcte_div_cell
module bcd_calendar_to_epoch_time_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   bcte_req_if.sink                             req_chan,
   bcte_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [bcte_pkg::PRESCALER_WIDTH-1:0] csr_write_data
);

   logic [bcte_pkg::PRESCALER_WIDTH-1:0] prescaler_ff, prescaler_in;
   logic                                 advance;
   bcte_pkg::cell_type                   chain [bcte_pkg::FRAC_WIDTH+1];

   assign prescaler_in = csr_write_enable ? csr_write_data : prescaler_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prescaler_ff <= bcte_pkg::PRESCALER_RESET;
      end else begin
         prescaler_ff <= prescaler_in;
      end
   end

   assign advance        = !chain[bcte_pkg::FRAC_WIDTH].valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   bcte_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_valid     (req_chan.valid),
      .req_time_word (req_chan.time_word),
      .req_date_word (req_chan.date_word),
      .req_subsecond (req_chan.subsecond),
      .prescaler     (prescaler_ff),
      .cell_out      (chain[0])
   );

   for (genvar i = 0; i < bcte_pkg::FRAC_WIDTH; i++) begin : g_cell
      bcte_div_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .prescaler    (prescaler_ff),
         .cell_in_prev (chain[i]),
         .cell_out     (chain[i+1])
      );
   end

   assign rsp_chan.valid         = chain[bcte_pkg::FRAC_WIDTH].valid;
   assign rsp_chan.epoch_seconds = chain[bcte_pkg::FRAC_WIDTH].epoch;
   assign rsp_chan.bad_fields    = chain[bcte_pkg::FRAC_WIDTH].bad;
   assign rsp_chan.fraction_ns   = chain[bcte_pkg::FRAC_WIDTH].bad
                                 ? '0 : chain[bcte_pkg::FRAC_WIDTH].word;

   a_bad_zero_fraction: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.bad_fields |-> rsp_chan.fraction_ns == '0)
      else $error("bad item with nonzero fraction");

   a_fraction_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.fraction_ns < bcte_pkg::NS_PER_SECOND)
      else $error("fraction not below one second");

   a_remainder_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.bad_fields
         |-> chain[bcte_pkg::FRAC_WIDTH].rem < prescaler_ff)
      else $error("divide remainder not below prescaler");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> prescaler_ff == $past(csr_write_data))
      else $error("prescaler write lost");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid right after reset");

endmodule
